// ===== hw/rtl/fmct_pkg.sv =====
// fmct_pkg: byte codes, result structs and the delimiter test shared by
// the framed message checker and tokenizer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fmct_pkg;

    localparam logic [7:0] B_STX = 8'h02;
    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_GS  = 8'h1D;
    localparam logic [7:0] B_RS  = 8'h1E;
    localparam logic [7:0] B_CR  = 8'h0D;
    localparam logic [7:0] B_LF  = 8'h0A;

    // configuration register indexes
    localparam logic CFG_MIN_LENGTH      = 1'b0;
    localparam logic CFG_SEPARATOR_INDEX = 1'b1;

    localparam logic [7:0] MIN_LENGTH_RST      = 8'd10;
    localparam logic [7:0] SEPARATOR_INDEX_RST = 8'd6;

    // token tags
    localparam logic [1:0] TAG_NONE  = 2'd0;
    localparam logic [1:0] TAG_TYPE  = 2'd1;
    localparam logic [1:0] TAG_NAME  = 2'd2;
    localparam logic [1:0] TAG_VALUE = 2'd3;

    typedef struct packed {
        logic frame_ok;
        logic start_ok;
        logic header_ok;
        logic group_sep_ok;
        logic record_sep_ok;
        logic end_ok;
        logic length_ok;
    } fmct_checks_t;

    typedef struct packed {
        logic [1:0] field_tag;
        logic       token_start;
    } fmct_tok_t;

    function automatic logic is_delim(input logic [7:0] b);
        return (b == B_STX) || (b == B_SOH) || (b == B_EOT) || (b == B_GS) ||
               (b == B_RS) || (b == B_CR) || (b == B_LF);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/framed_message_checker_tokenizer.sv =====
// Framed message checker and tokenizer, top level.
// Each accepted input beat appears as its result beat in the next cycle.
// Throughput: one beat per cycle; a new beat is taken whenever the result
// register is empty or being drained in the same cycle.
// Reset (rst_n, async, active low): result register empty, per-message
// state cleared, min_length = 10 and separator_index = 6.
`timescale 1ns / 1ps
`default_nettype none

module framed_message_checker_tokenizer #(
    parameter int MAX_LENGTH = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,

    // configuration write channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,

    // input byte channel
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,

    // result channel
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      echo_byte,
    output logic [1:0]      field_tag,
    output logic            token_start,
    output logic            frame_end,
    output logic            frame_ok,
    output logic            start_ok,
    output logic            header_ok,
    output logic            group_sep_ok,
    output logic            record_sep_ok,
    output logic            end_ok,
    output logic            length_ok
);

    // Configuration registers; writes are always taken.
    logic [7:0] min_length_reg;
    logic [7:0] sep_index_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= fmct_pkg::MIN_LENGTH_RST;
            sep_index_reg  <= fmct_pkg::SEPARATOR_INDEX_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fmct_pkg::CFG_MIN_LENGTH:      min_length_reg <= cfg_data;
                fmct_pkg::CFG_SEPARATOR_INDEX: sep_index_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input beat accepted: the result register is free or drains this cycle.
    logic out_valid_reg;
    logic step;

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    fmct_pkg::fmct_checks_t checks;
    fmct_pkg::fmct_tok_t    tok;

    // Framing checks: position counter and per-index byte compares.
    fmct_framing #(
        .MAX_LENGTH(MAX_LENGTH)
    ) u_framing (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .min_length      (min_length_reg),
        .separator_index (sep_index_reg),
        .checks          (checks)
    );

    // Token tagging on delimiter runs.
    fmct_tokenizer u_tokenizer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .tok       (tok)
    );

    // Result register. Check bits are only reported on the final byte.
    logic [7:0]             echo_reg;
    fmct_pkg::fmct_tok_t    tok_reg;
    logic                   end_reg;
    fmct_pkg::fmct_checks_t checks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            echo_reg   <= data_byte;
            tok_reg    <= tok;
            end_reg    <= last_byte;
            checks_reg <= last_byte ? checks : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign echo_byte     = echo_reg;
    assign field_tag     = tok_reg.field_tag;
    assign token_start   = tok_reg.token_start;
    assign frame_end     = end_reg;
    assign frame_ok      = checks_reg.frame_ok;
    assign start_ok      = checks_reg.start_ok;
    assign header_ok     = checks_reg.header_ok;
    assign group_sep_ok  = checks_reg.group_sep_ok;
    assign record_sep_ok = checks_reg.record_sep_ok;
    assign end_ok        = checks_reg.end_ok;
    assign length_ok     = checks_reg.length_ok;

`ifndef ASSERT_OFF
    // An empty result register must never hold off input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    // An accepted input beat always yields a result beat next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("accepted beat produced no result");

    // Overall pass only when every individual check passed.
    a_frame_ok_all: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_ok) |->
            (start_ok && header_ok && group_sep_ok && record_sep_ok &&
             end_ok && length_ok))
        else $error("frame_ok without all checks");

    // Check bits stay clear away from the final byte.
    a_checks_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !frame_end) |-> (checks_reg == '0))
        else $error("check bits set on non-final byte");

    // A token start always carries a real tag.
    a_start_tagged: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && token_start) |-> (field_tag != fmct_pkg::TAG_NONE))
        else $error("token start without tag");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/fmct_framing.sv =====
// fmct_framing: byte position counter and the six framing checks.
// Depends on fmct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmct_framing #(
    parameter int MAX_LENGTH = 256
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 last_byte,
    input  wire logic [7:0]           min_length,
    input  wire logic [7:0]           separator_index,
    output fmct_pkg::fmct_checks_t    checks
);

    localparam int PW = $clog2(MAX_LENGTH + 1);
    localparam int CW = (PW > 8) ? PW + 1 : 9;

    logic [PW-1:0] pos_reg, pos_next;
    logic          start_reg, start_next;
    logic          header_reg, header_next;
    logic          group_reg, group_next;
    logic          rs_found_reg, rs_found_next;
    logic          rs_place_reg, rs_place_next;

    logic          indexed;
    logic [CW-1:0] pos_w, sep_w, min_w, len_w;
    logic          at_start, at_header, at_group;
    logic          s_ok, h_ok, g_ok, r_ok, e_ok, l_ok;

    always_comb
    begin
        indexed   = pos_reg < PW'(MAX_LENGTH);
        pos_w     = CW'(pos_reg);
        sep_w     = CW'(separator_index);
        min_w     = CW'(min_length);
        len_w     = pos_w + CW'(1);
        at_start  = indexed && (pos_reg == '0);
        at_header = indexed && (pos_w == CW'(1));
        at_group  = indexed && (pos_w == sep_w);

        start_next    = at_start  ? (data_byte == fmct_pkg::B_STX) : start_reg;
        header_next   = at_header ? (data_byte == fmct_pkg::B_SOH) : header_reg;
        group_next    = at_group  ? (data_byte == fmct_pkg::B_GS)  : group_reg;
        rs_found_next = rs_found_reg;
        rs_place_next = rs_place_reg;
        if (!rs_found_reg && (data_byte == fmct_pkg::B_RS))
        begin
            rs_found_next = 1'b1;
            rs_place_next = pos_w > sep_w;
        end
        pos_next = indexed ? pos_reg + PW'(1) : pos_reg;

        // record separator check uses state from before this byte
        s_ok = start_next;
        h_ok = header_next;
        g_ok = group_next;
        r_ok = rs_found_reg && rs_place_reg;
        e_ok = data_byte == fmct_pkg::B_EOT;
        l_ok = len_w >= min_w;

        checks.frame_ok      = s_ok && h_ok && g_ok && r_ok && e_ok && l_ok;
        checks.start_ok      = s_ok;
        checks.header_ok     = h_ok;
        checks.group_sep_ok  = g_ok;
        checks.record_sep_ok = r_ok;
        checks.end_ok        = e_ok;
        checks.length_ok     = l_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            start_reg    <= 1'b0;
            header_reg   <= 1'b0;
            group_reg    <= 1'b0;
            rs_found_reg <= 1'b0;
            rs_place_reg <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                pos_reg      <= '0;
                start_reg    <= 1'b0;
                header_reg   <= 1'b0;
                group_reg    <= 1'b0;
                rs_found_reg <= 1'b0;
                rs_place_reg <= 1'b0;
            end
            else
            begin
                pos_reg      <= pos_next;
                start_reg    <= start_next;
                header_reg   <= header_next;
                group_reg    <= group_next;
                rs_found_reg <= rs_found_next;
                rs_place_reg <= rs_place_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fmct_tokenizer.sv =====
// fmct_tokenizer: splits the byte stream on delimiter runs and tags the
// first three tokens of a message. Depends on fmct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmct_tokenizer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    output fmct_pkg::fmct_tok_t    tok
);

    logic [1:0] count_reg, count_next;
    logic       inside_reg, inside_next;

    always_comb
    begin
        count_next      = count_reg;
        inside_next     = inside_reg;
        tok.field_tag   = fmct_pkg::TAG_NONE;
        tok.token_start = 1'b0;
        if (fmct_pkg::is_delim(data_byte))
        begin
            inside_next = 1'b0;
        end
        else if (inside_reg)
        begin
            tok.field_tag = count_reg;
        end
        else if (count_reg != fmct_pkg::TAG_VALUE)
        begin
            count_next      = count_reg + 2'd1;
            tok.field_tag   = count_next;
            tok.token_start = 1'b1;
            inside_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            inside_reg <= 1'b0;
        end
        else if (step)
        begin
            count_reg  <= last_byte ? 2'd0 : count_next;
            inside_reg <= last_byte ? 1'b0 : inside_next;
        end
    end

endmodule

`default_nettype wire
